@@ rtl/go_back_n_sender_defines.svh @@
// Assertion macros shared by the go-back-N sender modules.
// Each macro expects clk_i and rst_ni to be visible in the module that uses it.
`ifndef GO_BACK_N_SENDER_DEFINES_SVH
`define GO_BACK_N_SENDER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GBN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define GBN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/gbn_pkg.sv @@
// Types, codes and constants of the go-back-N sender.
// No dependencies; used by every module of the block.
`default_nettype none

package gbn_pkg;

  // Field widths.
  localparam int unsigned FRAME_W    = 16;
  localparam int unsigned WSIZE_W    = 5;
  localparam int unsigned TIMER_W    = 16;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Event codes on the op field.
  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK   = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WSIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

  // Configuration reset values.
  localparam logic [FRAME_W-1:0] TOTAL_RST   = 16'd0;
  localparam logic [WSIZE_W-1:0] WSIZE_RST   = 5'd5;
  localparam logic [TIMER_W-1:0] TIMEOUT_RST = 16'd2000;

  // Default for the largest window the sequencer will honour.
  localparam int unsigned MAX_WINDOW_DEF = 16;

  // Command queue between front and back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [FRAME_W-1:0] ack_number;
    logic               ack_corrupt;
  } in_item_t;

  typedef struct packed {
    logic               frame_valid;
    logic [FRAME_W-1:0] frame_number;
    logic               resend;
    logic               all_done;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] total_packets;
    logic [WSIZE_W-1:0] win_len;
    logic [TIMER_W-1:0] timeout_ticks;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_ACK,
    CMD_TICK,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [FRAME_W-1:0] ack_number;
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PLAN,
    S_SEND
  } back_state_e;

endpackage

`default_nettype wire

@@ rtl/gbn_front.sv @@
// Front end of the go-back-N sender: accepts events, classifies them and
// queues the resulting commands. Depends on gbn_pkg and the defines header.
`default_nettype none
`include "go_back_n_sender_defines.svh"

module gbn_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  gbn_pkg::in_item_t in_item_i,
  output logic            cmd_valid_o,
  input  logic            cmd_pop_i,
  output gbn_pkg::cmd_t   cmd_o
);
  import gbn_pkg::*;

  cmd_t              cmd_in;
  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push;

  // A corrupt acknowledgement becomes a no-op; it still yields at least one result beat.
  always_comb begin
    cmd_in.ack_number = in_item_i.ack_number;
    unique case (in_item_i.op)
      OP_START: cmd_in.kind = CMD_START;
      OP_ACK:   cmd_in.kind = in_item_i.ack_corrupt ? CMD_NOP : CMD_ACK;
      OP_TICK:  cmd_in.kind = CMD_TICK;
      default:  cmd_in.kind = CMD_NOP;
    endcase
  end

  assign in_stall_o  = (count_q == QCNT_W'(QDEPTH));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (cmd_pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !cmd_pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && cmd_pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  `GBN_ASSERT_IMP(a_count_bound, 1'b1, count_q <= QCNT_W'(QDEPTH), "queue overfilled")
  `GBN_ASSERT_IMP(a_pop_nonempty, cmd_pop_i, count_q != '0, "pop from empty queue")
  `GBN_ASSERT_NXT(a_pop_drains, cmd_pop_i && !push, count_q == $past(count_q) - 1'b1, "pop lost")

endmodule

`default_nettype wire

@@ rtl/gbn_back.sv @@
// Back end of the go-back-N sender: applies queued commands to the window state and
// emits one result beat per cycle in S_SEND unless stalled. Uses gbn_pkg and the defines header.
`default_nettype none
`include "go_back_n_sender_defines.svh"

module gbn_back #(
  parameter int unsigned MAX_WINDOW = gbn_pkg::MAX_WINDOW_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gbn_pkg::cfg_t     cfg_i,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  input  gbn_pkg::cmd_t     cmd_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output gbn_pkg::out_item_t out_item_o
);
  import gbn_pkg::*;

  localparam int unsigned WIN_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CMP_W = (WIN_W > WSIZE_W) ? WIN_W : WSIZE_W;

  back_state_e        state_q, state_d;
  logic [FRAME_W-1:0] base_q, base_d;
  logic [FRAME_W-1:0] next_q, next_d;
  logic [TIMER_W-1:0] wait_q, wait_d;
  logic               active_q, active_d;
  logic               rs_q, rs_d;
  logic               done_q, done_d;
  logic [FRAME_W-1:0] limit_q, limit_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic               can_load;
  logic [TIMER_W-1:0] wait_inc;
  logic [TIMER_W-1:0] timeout_eff;
  logic [CMP_W-1:0]   ws_ext;
  logic [CMP_W-1:0]   win_cmp;
  logic [FRAME_W:0]   base_plus_win;
  logic               plan_done;

  assign can_load    = !out_valid_q || !out_stall_i;
  assign wait_inc    = (wait_q == '1) ? wait_q : wait_q + 1'b1;
  assign timeout_eff = (cfg_i.timeout_ticks == '0) ? TIMER_W'(1) : cfg_i.timeout_ticks;

  // Window clamped to one at the bottom and to MAX_WINDOW at the top.
  assign ws_ext  = CMP_W'(cfg_i.win_len);
  assign win_cmp = (ws_ext == '0) ? CMP_W'(1) :
                   (ws_ext > CMP_W'(MAX_WINDOW)) ? CMP_W'(MAX_WINDOW) : ws_ext;
  assign base_plus_win = {1'b0, base_q} + (FRAME_W + 1)'(win_cmp);
  assign plan_done     = (base_q >= cfg_i.total_packets);

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    next_d      = next_q;
    wait_d      = wait_q;
    active_d    = active_q;
    rs_d        = rs_q;
    done_d      = done_q;
    limit_d     = limit_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    cmd_pop_o   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          rs_d      = 1'b0;
          state_d   = S_PLAN;
          unique case (cmd_i.kind)
            CMD_START: begin
              base_d   = '0;
              next_d   = '0;
              wait_d   = '0;
              active_d = 1'b1;
            end
            CMD_ACK: begin
              if (active_q && cmd_i.ack_number >= base_q && cmd_i.ack_number < next_q) begin
                base_d = cmd_i.ack_number + 1'b1;
                wait_d = '0;
              end
            end
            CMD_TICK: begin
              if (active_q) begin
                wait_d = wait_inc;
                if (wait_inc >= timeout_eff) begin
                  wait_d = '0;
                  next_d = base_q;
                  rs_d   = 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Close the session once the base reaches the total, then fix the
      // upper bound of this event's frames.
      S_PLAN: begin
        done_d  = plan_done;
        state_d = S_SEND;
        if (plan_done) begin
          active_d = 1'b0;
        end
        if (active_q && !plan_done) begin
          limit_d = (base_plus_win > {1'b0, cfg_i.total_packets}) ?
                    cfg_i.total_packets : base_plus_win[FRAME_W-1:0];
        end else begin
          limit_d = '0;
        end
      end

      S_SEND: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          if (next_q < limit_q) begin
            out_d.frame_valid  = 1'b1;
            out_d.frame_number = next_q;
            out_d.resend       = rs_q;
            out_d.all_done     = done_q;
            out_d.last         = (next_q + 1'b1 == limit_q);
            next_d             = next_q + 1'b1;
            if (next_q + 1'b1 == limit_q) begin
              state_d = S_IDLE;
            end
          end else begin
            out_d.frame_valid  = 1'b0;
            out_d.frame_number = '0;
            out_d.resend       = 1'b0;
            out_d.all_done     = done_q;
            out_d.last         = 1'b1;
            state_d            = S_IDLE;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= '0;
      next_q      <= '0;
      wait_q      <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      next_q      <= next_d;
      wait_q      <= wait_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rs_q    <= rs_d;
    done_q  <= done_d;
    limit_q <= limit_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `GBN_ASSERT_IMP(a_base_le_next, 1'b1, base_q <= next_q, "base passed next frame")
  `GBN_ASSERT_IMP(a_span, 1'b1, (next_q - base_q) <= FRAME_W'(MAX_WINDOW), "window overrun")
  `GBN_ASSERT_IMP(a_status_last, out_valid_q && !out_q.frame_valid, out_q.last, "status not last")

endmodule

`default_nettype wire

@@ rtl/go_back_n_sender.sv @@
// Go-back-N sender window control. Each event (start, acknowledgement or
// timer tick) passes through the back end's bookkeeping states, S_IDLE and
// S_PLAN, and then yields 1 to MAX_WINDOW result beats in S_SEND. The
// back-end sequencer drives one beat per cycle through its output register
// while the output is not stalled. A two-entry command queue in front lets
// events be taken while the back end is still busy with an earlier one.
// Depends on gbn_pkg, gbn_front and gbn_back.
`default_nettype none

module go_back_n_sender #(
  parameter int unsigned MAX_WINDOW = gbn_pkg::MAX_WINDOW_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  gbn_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output gbn_pkg::out_item_t             out_item_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import gbn_pkg::*;

  cfg_t cfg_q;
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // Configuration registers. Writes are expected only while the block is
  // idle, so the back end reads them directly. An unknown index is dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.total_packets <= TOTAL_RST;
      cfg_q.win_len       <= WSIZE_RST;
      cfg_q.timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_TOTAL:   cfg_q.total_packets <= cfg_data_i[FRAME_W-1:0];
        CFG_WSIZE:   cfg_q.win_len       <= cfg_data_i[WSIZE_W-1:0];
        CFG_TIMEOUT: cfg_q.timeout_ticks <= cfg_data_i[TIMER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The front end classifies each event and queues it; a corrupt
  // acknowledgement is turned into a no-op there.
  gbn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  // The back end owns the window state and the output register.
  gbn_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

@@ tb/go_back_n_sender_checker.sv @@
// Checker for the go-back-N sender: follows the register, event and result channels,
// predicts every result beat and compares it field by field.
// Depends on gbn_pkg only.
module go_back_n_sender_checker #(
  parameter int unsigned MAX_WINDOW = gbn_pkg::MAX_WINDOW_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  gbn_pkg::in_item_t              in_item_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  gbn_pkg::out_item_t             out_item_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                    failures_o,
  output int unsigned                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import gbn_pkg::*;

  localparam int unsigned PRINT_CAP = 100;

  // Register copies.
  logic [FRAME_W-1:0] total_frames;
  logic [WSIZE_W-1:0] window_req;
  logic [TIMER_W-1:0] timeout_limit;

  // Window state.
  logic [FRAME_W-1:0] base;
  logic [FRAME_W-1:0] send_ptr;
  logic [TIMER_W-1:0] idle_ticks;
  logic               in_session;

  out_item_t frame_requests[$];

  task automatic report_mismatch(input string what);
    if (failures_o < PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    failures_o++;
  endtask

  function automatic string field_msg(input string name, input logic [FRAME_W-1:0] got,
                                      input logic [FRAME_W-1:0] want);
    return $sformatf("%s is 0x%0h, expected 0x%0h", name, got, want);
  endfunction

  // Applies one event to the window and queues the beats it should cause.
  task automatic advance_window(input in_item_t ev);
    int unsigned win;
    int unsigned room;
    int unsigned limit;
    int unsigned timeout_eff;
    logic        resend_flag;
    logic        done_flag;
    out_item_t   req;
    out_item_t   burst[$];
    resend_flag = 1'b0;
    case (ev.op)
      OP_START: begin
        base       = '0;
        send_ptr   = '0;
        idle_ticks = '0;
        in_session = 1'b1;
      end
      OP_ACK: begin
        if (in_session && !ev.ack_corrupt && ev.ack_number >= base &&
            ev.ack_number < send_ptr) begin
          base       = ev.ack_number + 1'b1;
          idle_ticks = '0;
        end
      end
      OP_TICK: begin
        if (in_session) begin
          timeout_eff = (timeout_limit == '0) ? 1 : timeout_limit;
          if (idle_ticks != '1) idle_ticks = idle_ticks + 1'b1;
          if (idle_ticks >= timeout_eff) begin
            idle_ticks  = '0;
            send_ptr    = base;
            resend_flag = 1'b1;
          end
        end
      end
      default: ;
    endcase

    done_flag = (base >= total_frames);
    if (done_flag) in_session = 1'b0;

    if (in_session) begin
      win = (window_req == '0) ? 1 : window_req;
      if (win > MAX_WINDOW) win = MAX_WINDOW;
      room = total_frames - base;
      if (win > room) win = room;
      limit = base + win;
      while (send_ptr < limit && send_ptr < total_frames && burst.size() < MAX_WINDOW) begin
        req.frame_valid  = 1'b1;
        req.frame_number = send_ptr;
        req.resend       = resend_flag;
        req.all_done     = done_flag;
        req.last         = 1'b0;
        burst.push_back(req);
        send_ptr = send_ptr + 1'b1;
      end
    end

    // With nothing to send a single status beat goes out instead.
    if (burst.size() == 0) begin
      req          = '0;
      req.all_done = done_flag;
      req.last     = 1'b1;
      burst.push_back(req);
    end else begin
      req      = burst.pop_back();
      req.last = 1'b1;
      burst.push_back(req);
    end
    foreach (burst[i]) frame_requests.push_back(burst[i]);
  endtask

  task automatic check_beat(input out_item_t got);
    out_item_t want;
    if (frame_requests.size() == 0) begin
      report_mismatch($sformatf("result beat for frame 0x%0h with nothing expected",
                                got.frame_number));
      return;
    end
    want = frame_requests.pop_front();
    if (got.frame_valid !== want.frame_valid) begin
      report_mismatch(field_msg("frame_valid", got.frame_valid, want.frame_valid));
    end
    if (got.frame_number !== want.frame_number) begin
      report_mismatch(field_msg("frame_number", got.frame_number, want.frame_number));
    end
    if (got.resend !== want.resend) begin
      report_mismatch(field_msg("resend", got.resend, want.resend));
    end
    if (got.all_done !== want.all_done) begin
      report_mismatch(field_msg("all_done", got.all_done, want.all_done));
    end
    if (got.last !== want.last) begin
      report_mismatch(field_msg("last", got.last, want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_frames  = TOTAL_RST;
      window_req    = WSIZE_RST;
      timeout_limit = TIMEOUT_RST;
      base          = '0;
      send_ptr      = '0;
      idle_ticks    = '0;
      in_session    = 1'b0;
      frame_requests.delete();
      failures_o    = 0;
      pending_o     = 0;
    end else begin
      // Result beats are compared first: none of them can stem from an event taken now.
      if (out_valid_i && !out_stall_i) check_beat(out_item_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TOTAL:   total_frames  = cfg_data_i;
          CFG_WSIZE:   window_req    = cfg_data_i[WSIZE_W-1:0];
          CFG_TIMEOUT: timeout_limit = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) advance_window(in_item_i);
      pending_o = frame_requests.size();
    end
  end

endmodule

@@ tb/go_back_n_sender_test.sv @@
// Testbench top for the go-back-N sender: clock, reset, register writes, event stimulus,
// random back-pressure and the verdict. Depends on gbn_pkg, go_back_n_sender and
// go_back_n_sender_checker.
module go_back_n_sender_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gbn_pkg::*;

  localparam int unsigned     MAX_WINDOW    = MAX_WINDOW_DEF;
  localparam int unsigned     RESET_CYCLES  = 12;
  localparam int unsigned     RANDOM_EVENTS = 400;
  localparam int unsigned     SETTLE_CYCLES = 2 * (MAX_WINDOW + 2);
  localparam int unsigned     LONG_HOLD     = 300;
  localparam longint unsigned CYCLE_LIMIT   = 2_000_000;

  // The op field has one code left unused, and the register index one spare slot.
  localparam logic [OP_W-1:0]      OP_SPARE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned     failures;
  int unsigned     pending;
  longint unsigned cycle_count = 0;

  // Shaping of the stimulus: calm phases offer events back to back, and the receiver
  // is asked once to hold off for a long stretch.
  logic calm = 1'b0;
  logic hold_request = 1'b0;

  // Latest result beats, used to aim acknowledgements near the frames in flight and to see done.
  logic [FRAME_W-1:0] latest_frame = '0;
  logic               latest_done = 1'b0;

  go_back_n_sender #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  go_back_n_sender_checker #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_item_i  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .failures_o  (failures),
    .pending_o   (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("go_back_n_sender regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if (out_item.frame_valid) latest_frame <= out_item.frame_number;
      latest_done <= out_item.all_done;
    end
  end

  // Gap lengths for both sides: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: alternating runs of acceptance and stalls. Once asked, it holds off while
  // the command queue fills and the input is stalled.
  initial begin : receiver
    int unsigned run;
    int unsigned hold;
    logic        held_long;
    held_long = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_request && !held_long) begin
        held_long = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        run = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
        out_stall <= 1'b0;
        repeat (run) @(posedge clk);
        hold = pick_gap();
        if (hold != 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
        end
      end
    end
  end

  // Offers one event beat and returns at the edge that takes it. Valid is left high so
  // that a following event can go out back to back.
  task automatic push_event(input logic [OP_W-1:0] op, input logic [FRAME_W-1:0] ack,
                            input logic corrupt);
    int unsigned gap;
    in_item_t    ev;
    gap           = calm ? 0 : pick_gap();
    ev.op          = op;
    ev.ack_number  = ack;
    ev.ack_corrupt = corrupt;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= ev;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] total,
                           input logic [CFG_DATA_W-1:0] wsize,
                           input logic [CFG_DATA_W-1:0] timeout);
    write_reg(CFG_TOTAL, total);
    write_reg(CFG_WSIZE, wsize);
    write_reg(CFG_TIMEOUT, timeout);
    cfg_valid <= 1'b0;
  endtask

  // Stops offering events, waits for every predicted beat and lets the back end go idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned           random_events;
    int unsigned           steps;
    int unsigned           r;
    logic                  first_phase;
    logic [FRAME_W-1:0]    ack;
    logic [FRAME_W-1:0]    near;
    logic [CFG_DATA_W-1:0] total;
    logic [CFG_DATA_W-1:0] wsize;
    logic [CFG_DATA_W-1:0] timeout;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A write to the spare index must leave every register alone.
    write_reg(CFG_SPARE, 16'h5A5A);
    configure(16'd10, 16'd4, 16'd3);
    // Before any session, acknowledgements, ticks and the unused code change nothing.
    push_event(OP_TICK, 16'd0, 1'b0);
    push_event(OP_ACK, 16'd0, 1'b0);
    push_event(OP_SPARE, 16'hFFFF, 1'b1);
    // Start sends frames 0 to 3; then a corrupt acknowledgement, one for a frame not
    // yet sent and, after the window slides, one below the base are all ignored.
    push_event(OP_START, 16'd0, 1'b0);
    push_event(OP_ACK, 16'd0, 1'b1);
    push_event(OP_ACK, 16'd7, 1'b0);
    push_event(OP_ACK, 16'd1, 1'b0);
    push_event(OP_ACK, 16'd0, 1'b0);
    // The third tick without progress times out and resends frames 2 to 5.
    push_event(OP_TICK, 16'd0, 1'b0);
    push_event(OP_TICK, 16'd0, 1'b0);
    push_event(OP_TICK, 16'd0, 1'b0);
    // Slide to the end: the session finishes and later ticks only report done.
    push_event(OP_ACK, 16'd5, 1'b0);
    push_event(OP_ACK, 16'd9, 1'b0);
    push_event(OP_TICK, 16'd0, 1'b0);
    settle();

    // Widest window (an oversized setting saturates) and a zero timeout, which acts
    // as one tick.
    configure(16'hFFFF, 16'hFFFF, 16'd0);
    push_event(OP_START, 16'hFFFF, 1'b1);
    push_event(OP_ACK, 16'hFFFF, 1'b1);
    push_event(OP_TICK, 16'hFFFF, 1'b1);
    push_event(OP_ACK, 16'd15, 1'b0);
    settle();

    // An empty session is finished as soon as it starts.
    configure(16'd0, 16'd0, 16'hFFFF);
    push_event(OP_START, 16'd0, 1'b0);
    settle();

    // A zero window size behaves as a window of one.
    configure(16'd100, 16'd0, 16'd2);
    push_event(OP_START, 16'd0, 1'b0);
    push_event(OP_ACK, 16'd0, 1'b0);
    settle();

    // The total is cut below the frames already sent, then down to the base itself.
    configure(16'd200, 16'd8, 16'd2);
    push_event(OP_START, 16'd0, 1'b0);
    settle();
    configure(16'd3, 16'd8, 16'd2);
    push_event(OP_ACK, 16'd0, 1'b0);
    push_event(OP_TICK, 16'd0, 1'b0);
    push_event(OP_TICK, 16'd0, 1'b0);
    settle();
    configure(16'd1, 16'd8, 16'd2);
    push_event(OP_TICK, 16'd0, 1'b0);
    settle();

    // Random part: sessions of random size and timing, mostly well-formed traffic with
    // acknowledgements aimed at the frames in flight, plus some noise.
    random_events = 0;
    first_phase   = 1'b1;
    while (random_events < RANDOM_EVENTS) begin
      r     = $urandom_range(0, 9);
      total = (r < 7) ? 16'($urandom_range(1, 40)) :
              (r == 7) ? 16'd0 :
              (r == 8) ? 16'($urandom_range(0, 65535)) : 16'hFFFF;
      r     = $urandom_range(0, 9);
      wsize = (r < 7) ? 16'($urandom_range(1, 16)) :
              (r == 7) ? 16'd0 :
              (r == 8) ? 16'($urandom_range(17, 31)) : 16'($urandom_range(0, 65535));
      r       = $urandom_range(0, 9);
      timeout = (r < 7) ? 16'($urandom_range(1, 6)) :
                (r == 7) ? 16'd0 : 16'($urandom_range(0, 65535));
      configure(total, wsize, timeout);
      calm = ($urandom_range(0, 3) == 0);

      push_event(OP_START, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      random_events++;
      if (first_phase) begin
        hold_request = 1'b1;
        first_phase  = 1'b0;
      end

      steps = $urandom_range(8, 40);
      for (int k = 0; k < steps; k++) begin
        // Once the session has finished further events would only be ignored.
        if (k >= 4 && latest_done) break;
        r    = $urandom_range(0, 99);
        ack  = 16'($urandom_range(0, 65535));
        near = (latest_frame > 3) ? latest_frame - 16'($urandom_range(0, 3)) :
                                    16'($urandom_range(0, latest_frame));
        if (r < 45) begin
          push_event(OP_ACK, near, 1'b0);
        end else if (r < 55) begin
          push_event(OP_ACK, near, 1'b1);
        end else if (r < 62) begin
          push_event(OP_ACK, ack, 1'($urandom_range(0, 1)));
        end else if (r < 90) begin
          push_event(OP_TICK, ack, 1'($urandom_range(0, 1)));
        end else if (r < 94) begin
          push_event(OP_SPARE, ack, 1'($urandom_range(0, 1)));
        end else if (r < 97) begin
          push_event(OP_START, ack, 1'($urandom_range(0, 1)));
        end else begin
          // Acknowledgement just beyond the latest frame seen on the output.
          push_event(OP_ACK, latest_frame + 16'($urandom_range(1, 3)), 1'b0);
        end
        random_events++;
      end
      settle();
    end

    if (failures == 0) begin
      $display("go_back_n_sender regression: pass");
    end else begin
      $display("go_back_n_sender regression: fail");
    end
    $finish;
  end

endmodule
